// ===== rtl/core/kmki_pkg.sv =====
// Shared types, constants and the key lookup table of the keypad matrix key injector.
// Used by the channel interfaces, the key queue and the top level; depends on nothing.
package kmki_pkg;

  localparam int ACTION_W    = 3;
  localparam int KEY_W       = 6;
  localparam int OFFSET_W    = 2;
  localparam int DATA_W      = 16;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 4;
  localparam int TICK_W      = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int ROM_SIZE    = 55;
  localparam int QUEUE_DEPTH = 16;

  localparam logic [KEY_W-1:0]  KEY_NONE    = 6'd0;
  localparam logic [KEY_W-1:0]  KEY_STOP    = 6'd55;
  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_QUEUE_KEY  = 3'd1,
    ACT_READ_BYTE  = 3'd2,
    ACT_READ_WORD  = 3'd3,
    ACT_WRITE_BYTE = 3'd4,
    ACT_WRITE_WORD = 3'd5
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRESS_TICKS   = 1'd0,
    REG_RELEASE_TICKS = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } key_entry_t;

  // Commands from the sequencer to the key queue.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [KEY_W-1:0] key;
  } queue_cmd_t;

  // Column patterns; the row bit follows from the key's group below.
  localparam logic [COL_W-1:0] KEY_COL [ROM_SIZE] = '{
    9'h000,
    9'h00c, 9'h014, 9'h024, 9'h044, 9'h084, 9'h104,
    9'h018, 9'h028, 9'h048, 9'h088, 9'h108,
    9'h030, 9'h050, 9'h090, 9'h110,
    9'h060, 9'h0a0, 9'h120, 9'h0c0,
    9'h00c, 9'h014, 9'h024, 9'h044, 9'h084, 9'h104,
    9'h018, 9'h028, 9'h048, 9'h088, 9'h108,
    9'h030, 9'h050, 9'h090, 9'h110,
    9'h060, 9'h0a0, 9'h120, 9'h0c0, 9'h140,
    9'h00c, 9'h014, 9'h024, 9'h044, 9'h084,
    9'h018, 9'h028, 9'h048, 9'h088,
    9'h030, 9'h050, 9'h090,
    9'h060, 9'h0a0, 9'h0c0
  };

  // Codes past the table act like the empty key.
  function automatic key_entry_t key_lookup(input logic [KEY_W-1:0] key);
    key_entry_t ent;
    ent.row = '0;
    ent.col = '0;
    if (key < KEY_W'(ROM_SIZE)) begin
      ent.col = KEY_COL[key];
      if (key == KEY_NONE) begin
        ent.row = 4'h0;
      end else if (key < 6'd20) begin
        ent.row = 4'h2;
      end else if (key < 6'd40) begin
        ent.row = 4'h4;
      end else begin
        ent.row = 4'h8;
      end
    end
    return ent;
  endfunction

endpackage

// ===== rtl/core/kmki_item_if.sv =====
// Input channel of the keypad matrix key injector: valid, ready and one input item.
// Depends on kmki_pkg for the field widths.
interface kmki_item_if;
  logic                           valid;
  logic                           ready;
  logic [kmki_pkg::ACTION_W-1:0]  action;
  logic [kmki_pkg::KEY_W-1:0]     key_code;
  logic [kmki_pkg::OFFSET_W-1:0]  offset;
  logic [kmki_pkg::DATA_W-1:0]    write_data;

  modport source (output valid, action, key_code, offset, write_data, input ready);
  modport sink   (input valid, action, key_code, offset, write_data, output ready);
endinterface

// ===== rtl/core/kmki_result_if.sv =====
// Result channel of the keypad matrix key injector: valid, ready and one result item.
// Depends on kmki_pkg for the field widths.
interface kmki_result_if;
  logic                         valid;
  logic                         ready;
  logic [kmki_pkg::DATA_W-1:0]  read_data;
  logic [kmki_pkg::COL_W-1:0]   column_word;
  logic                         key_held;

  modport source (output valid, read_data, column_word, key_held, input ready);
  modport sink   (input valid, read_data, column_word, key_held, output ready);
endinterface

// ===== rtl/core/kmki_queue.sv =====
// Ring buffer of queued key codes with a registered-read memory and a head register.
// Depends on kmki_pkg for the command struct and key width.
module kmki_queue #(
  parameter int QueueDepth = kmki_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kmki_pkg::queue_cmd_t        cmd,
  output logic                        empty,
  output logic [kmki_pkg::KEY_W-1:0]  head
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  logic [kmki_pkg::KEY_W-1:0] mem [QueueDepth];
  logic [PtrW-1:0]            wr_ptr;
  logic [PtrW-1:0]            rd_ptr;
  logic [PtrW-1:0]            rd_ptr_next;
  logic [kmki_pkg::KEY_W-1:0] head_mem;
  logic [kmki_pkg::KEY_W-1:0] byp_key;
  logic                       byp_valid;

  // The write pointer advances on every push, even when full, so an overflow wraps over unread keys.
  assign rd_ptr_next = cmd.pop ? rd_ptr + PtrW'(1) : rd_ptr;
  assign empty       = (rd_ptr == wr_ptr);
  assign head        = byp_valid ? byp_key : head_mem;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr] <= cmd.key;
    end
    head_mem <= mem[rd_ptr_next];
    byp_key  <= cmd.key;
  end

  // A key written to the entry that becomes the head is forwarded past the memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      byp_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      rd_ptr    <= rd_ptr_next;
      byp_valid <= cmd.push && (wr_ptr == rd_ptr_next);
    end
  end

endmodule

// ===== rtl/core/keypad_matrix_key_injector.sv =====
// Keypad matrix key injector: emulated calculator keypad with a key queue.
// Channels: items (sink) carries one action per transfer: tick, queue key, byte or
// word read, byte or word write. results (source) returns exactly one result per
// item: read data, the column word and the key-held flag as they stand after it.
// Configuration: cfg_we, cfg_index and cfg_data write press_ticks (index 0) and
// release_ticks (index 1); write them only while no item is in flight.
// Latency: the result of an item is valid in the cycle after its transfer.
// Throughput: one item per cycle while results are taken; all work is a single
// pass from the current state to the result register. The key queue memory reads
// its next head ahead, with a bypass for a key queued straight into the head slot.
// Reset: synchronous; the state machine waits, the queue is empty, the row and
// column words are zero and both tick counts return to 16. Queue entries are not
// cleared.
// When the receiver stalls, items is still ready as long as the result register
// holds no result; otherwise items holds off.
module keypad_matrix_key_injector #(
  parameter int QueueDepth = kmki_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kmki_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kmki_pkg::TICK_W-1:0]      cfg_data,
  kmki_item_if.sink                        items,
  kmki_result_if.source                    results
);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DOWN = 2'd1,
    PH_UP   = 2'd2
  } phase_t;

  phase_t                         phase, phase_next;
  logic [kmki_pkg::TICK_W-1:0]    tick_count, tick_count_next;
  logic [kmki_pkg::KEY_W-1:0]     cur_key, cur_key_next;
  logic [kmki_pkg::DATA_W-1:0]    row_word, row_word_next;
  logic [kmki_pkg::COL_W-1:0]     col_word, col_word_next;
  logic [kmki_pkg::TICK_W-1:0]    press_ticks;
  logic [kmki_pkg::TICK_W-1:0]    release_ticks;
  logic [kmki_pkg::DATA_W-1:0]    rd_next;
  logic [kmki_pkg::TICK_W-1:0]    count_dec;
  logic                           upd_cols;
  logic                           accept;
  logic                           q_empty;
  logic [kmki_pkg::KEY_W-1:0]     q_head;
  kmki_pkg::queue_cmd_t           q_cmd;
  kmki_pkg::key_entry_t           ent;

  assign items.ready = !results.valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign count_dec   = tick_count - kmki_pkg::TICK_W'(1);

  kmki_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .cmd   (q_cmd),
    .empty (q_empty),
    .head  (q_head)
  );

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    cur_key_next    = cur_key;
    row_word_next   = row_word;
    upd_cols        = 1'b0;
    rd_next         = '0;
    q_cmd.push      = 1'b0;
    q_cmd.pop       = 1'b0;
    q_cmd.key       = items.key_code;

    if (accept) begin
      case (items.action)
        kmki_pkg::ACT_TICK: begin
          unique case (phase)
            PH_WAIT: begin
              if (!q_empty) begin
                q_cmd.pop = 1'b1;
                // A stop code is consumed without starting a press.
                if (q_head != kmki_pkg::KEY_STOP) begin
                  cur_key_next    = q_head;
                  tick_count_next = press_ticks;
                  phase_next      = PH_DOWN;
                  upd_cols        = 1'b1;
                end
              end
            end
            PH_DOWN: begin
              tick_count_next = count_dec;
              if (count_dec == '0) begin
                cur_key_next    = kmki_pkg::KEY_NONE;
                tick_count_next = release_ticks;
                phase_next      = PH_UP;
                upd_cols        = 1'b1;
              end
            end
            default: begin
              tick_count_next = count_dec;
              if (count_dec == '0) begin
                phase_next = PH_WAIT;
              end
            end
          endcase
        end
        kmki_pkg::ACT_QUEUE_KEY: begin
          q_cmd.push = 1'b1;
        end
        kmki_pkg::ACT_READ_BYTE: begin
          case (items.offset)
            2'd0:    rd_next = {8'h00, col_word[7:0]};
            2'd1:    rd_next = {15'h0000, col_word[8]};
            2'd2:    rd_next = {8'h00, row_word[7:0]};
            default: rd_next = {8'h00, row_word[15:8]};
          endcase
        end
        kmki_pkg::ACT_READ_WORD: begin
          rd_next = items.offset[1] ? row_word : {7'h00, col_word};
        end
        kmki_pkg::ACT_WRITE_BYTE: begin
          // Bytes of the column word are rewritten by the column update anyway.
          if (items.offset == 2'd2) begin
            row_word_next[7:0] = items.write_data[7:0];
          end else if (items.offset == 2'd3) begin
            row_word_next[15:8] = items.write_data[7:0];
          end
          upd_cols = 1'b1;
        end
        kmki_pkg::ACT_WRITE_WORD: begin
          if (items.offset[1]) begin
            row_word_next = items.write_data;
          end
          upd_cols = 1'b1;
        end
        default: begin
        end
      endcase
    end

    ent           = kmki_pkg::key_lookup(cur_key_next);
    col_word_next = col_word;
    if (upd_cols) begin
      col_word_next = ((row_word_next[kmki_pkg::ROW_W-1:0] & ent.row) != '0) ? ent.col : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      tick_count    <= '0;
      cur_key       <= kmki_pkg::KEY_NONE;
      row_word      <= '0;
      col_word      <= '0;
      press_ticks   <= kmki_pkg::TICKS_RESET;
      release_ticks <= kmki_pkg::TICKS_RESET;
      results.valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      cur_key    <= cur_key_next;
      row_word   <= row_word_next;
      col_word   <= col_word_next;
      if (cfg_we) begin
        unique case (cfg_index)
          kmki_pkg::REG_PRESS_TICKS:   press_ticks   <= cfg_data;
          kmki_pkg::REG_RELEASE_TICKS: release_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.read_data   <= rd_next;
      results.column_word <= col_word_next;
      results.key_held    <= (phase_next == PH_DOWN);
    end
  end

`ifndef SYNTHESIS
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> items.ready)
    else $error("input not ready while the result register is empty");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> results.valid)
    else $error("transferred item produced no result");

  a_no_key_outside_press : assert property (@(posedge clk) disable iff (rst)
    (phase != PH_DOWN) |-> (cur_key == kmki_pkg::KEY_NONE))
    else $error("a key is current outside the pressed phase");

  a_cols_need_row : assert property (@(posedge clk) disable iff (rst)
    (row_word[kmki_pkg::ROW_W-1:0] == '0) |-> (col_word == '0))
    else $error("column word set with no row line enabled");
`endif

endmodule

// ===== test/tb_keypad_matrix_key_injector.sv =====
// Self-checking testbench for keypad_matrix_key_injector: directed table, random traffic,
// longer tick runs at larger counts, checked against the table or an in-bench predictor.
// Depends on kmki_pkg, kmki_item_if, kmki_result_if and the injector top level.
module tb_keypad_matrix_key_injector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kmki_pkg::ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [kmki_pkg::ACTION_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int                            KEY_TABLE_SIZE = 55;
  localparam int                            MAX_PRINTED = 20;
  localparam int                            RANDOM_ITEMS = 250;

  typedef enum logic [1:0] {PH_WAIT, PH_DOWN, PH_UP} press_phase_t;

  typedef struct packed {
    logic [kmki_pkg::ACTION_W-1:0] act;
    logic [kmki_pkg::KEY_W-1:0]    key;
    logic [kmki_pkg::OFFSET_W-1:0] off;
    logic [kmki_pkg::DATA_W-1:0]   data;
  } keypad_req_t;

  typedef struct packed {
    logic [kmki_pkg::DATA_W-1:0] rdata;
    logic [kmki_pkg::COL_W-1:0]  col;
    logic                        held;
  } keypad_obs_t;

  typedef struct packed {
    keypad_req_t req;
    logic        known;
    keypad_obs_t obs;
  } script_row_t;

  localparam logic [kmki_pkg::COL_W-1:0] COLUMN_OF_KEY [KEY_TABLE_SIZE] = '{
    9'h000,
    9'h00c, 9'h014, 9'h024, 9'h044, 9'h084, 9'h104,
    9'h018, 9'h028, 9'h048, 9'h088, 9'h108,
    9'h030, 9'h050, 9'h090, 9'h110,
    9'h060, 9'h0a0, 9'h120, 9'h0c0,
    9'h00c, 9'h014, 9'h024, 9'h044, 9'h084, 9'h104,
    9'h018, 9'h028, 9'h048, 9'h088, 9'h108,
    9'h030, 9'h050, 9'h090, 9'h110,
    9'h060, 9'h0a0, 9'h120, 9'h0c0, 9'h140,
    9'h00c, 9'h014, 9'h024, 9'h044, 9'h084,
    9'h018, 9'h028, 9'h048, 9'h088,
    9'h030, 9'h050, 9'h090,
    9'h060, 9'h0a0, 9'h0c0
  };

  // Rows flagged known carry an expectation read straight off the spec; the rest
  // go through the predictor.
  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{kmki_pkg::ACT_READ_WORD,  6'd0,  2'd0, 16'h0000}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_READ_BYTE,  6'd0,  2'd3, 16'hffff}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{ACT_RSVD6,                6'd63, 2'd3, 16'hffff}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{ACT_RSVD7,                6'd63, 2'd3, 16'hffff}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_WRITE_WORD, 6'd0,  2'd2, 16'hffff}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_WRITE_BYTE, 6'd0,  2'd0, 16'h00ff}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_WRITE_WORD, 6'd0,  2'd1, 16'hffff}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_READ_WORD,  6'd0,  2'd3, 16'h0000}, 1'b1, '{16'hffff, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_QUEUE_KEY,  6'd1,  2'd0, 16'h0000}, 1'b1, '{16'h0000, 9'h000, 1'b0}},
    '{'{kmki_pkg::ACT_TICK,       6'd0,  2'd0, 16'h0000}, 1'b1, '{16'h0000, 9'h00c, 1'b1}},
    '{'{kmki_pkg::ACT_READ_BYTE,  6'd0,  2'd0, 16'h0000}, 1'b1, '{16'h000c, 9'h00c, 1'b1}},
    '{'{kmki_pkg::ACT_WRITE_WORD, 6'd0,  2'd2, 16'h0000}, 1'b1, '{16'h0000, 9'h000, 1'b1}},
    '{'{kmki_pkg::ACT_WRITE_BYTE, 6'd0,  2'd2, 16'h0004}, 1'b0, '0},
    '{'{kmki_pkg::ACT_WRITE_BYTE, 6'd0,  2'd2, 16'h0002}, 1'b0, '0},
    '{'{kmki_pkg::ACT_READ_WORD,  6'd0,  2'd1, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_QUEUE_KEY,  kmki_pkg::KEY_STOP, 2'd0, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_QUEUE_KEY,  6'd63, 2'd0, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_QUEUE_KEY,  kmki_pkg::KEY_NONE, 2'd0, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_QUEUE_KEY,  6'd39, 2'd0, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_QUEUE_KEY,  6'd54, 2'd0, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_WRITE_WORD, 6'd0,  2'd2, 16'h000e}, 1'b0, '0},
    '{'{kmki_pkg::ACT_TICK,       6'd0,  2'd0, 16'h0000}, 1'b0, '0},
    '{'{kmki_pkg::ACT_READ_BYTE,  6'd0,  2'd1, 16'h0000}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [kmki_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [kmki_pkg::TICK_W-1:0] cfg_data;

  kmki_item_if   item_ch ();
  kmki_result_if result_ch ();

  keypad_matrix_key_injector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .results   (result_ch)
  );

  always #5ns clk = ~clk;

  // Predictor state.
  press_phase_t                sim_phase;
  logic [kmki_pkg::TICK_W-1:0] sim_count;
  logic [kmki_pkg::KEY_W-1:0]  key_fifo [kmki_pkg::QUEUE_DEPTH];
  logic [3:0]                  fifo_rd;
  logic [3:0]                  fifo_wr;
  logic [kmki_pkg::KEY_W-1:0]  held_key;
  logic [7:0]                  win_bytes [4];
  logic [kmki_pkg::TICK_W-1:0] press_len;
  logic [kmki_pkg::TICK_W-1:0] release_len;

  keypad_obs_t pending_obs [$];
  int errors;
  int transfers_in;
  int results_seen;
  int presses;
  int stops_dropped;
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;

  task automatic report_mismatch(input string field, input logic [kmki_pkg::DATA_W-1:0] got,
                                 input logic [kmki_pkg::DATA_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("mismatch on %s at result %0d: got %h, expected %h", field, results_seen,
               got, want);
    end
  endtask

  function automatic logic [kmki_pkg::ROW_W-1:0] row_bit_of(
      input logic [kmki_pkg::KEY_W-1:0] key);
    if (key == kmki_pkg::KEY_NONE || key >= kmki_pkg::KEY_W'(KEY_TABLE_SIZE)) return 4'h0;
    if (key < 6'd20) return 4'h2;
    if (key < 6'd40) return 4'h4;
    return 4'h8;
  endfunction

  function automatic void refresh_columns();
    logic [kmki_pkg::DATA_W-1:0] row_word;
    logic [kmki_pkg::COL_W-1:0]  col;
    row_word = {win_bytes[3], win_bytes[2]};
    col = '0;
    if ((row_word[kmki_pkg::ROW_W-1:0] & row_bit_of(held_key)) != '0 &&
        held_key < kmki_pkg::KEY_W'(KEY_TABLE_SIZE))
      col = COLUMN_OF_KEY[held_key];
    win_bytes[0] = col[7:0];
    win_bytes[1] = {7'd0, col[8]};
  endfunction

  function automatic void advance_tick();
    logic [kmki_pkg::KEY_W-1:0] popped;
    case (sim_phase)
      PH_WAIT: begin
        if (fifo_rd != fifo_wr) begin
          popped = key_fifo[fifo_rd];
          fifo_rd = fifo_rd + 4'd1;
          if (popped == kmki_pkg::KEY_STOP) begin
            stops_dropped++;
          end else begin
            held_key = popped;
            sim_count = press_len;
            sim_phase = PH_DOWN;
            presses++;
            refresh_columns();
          end
        end
      end
      PH_DOWN: begin
        sim_count = sim_count - 16'd1;
        if (sim_count == '0) begin
          held_key = kmki_pkg::KEY_NONE;
          sim_count = release_len;
          sim_phase = PH_UP;
          refresh_columns();
        end
      end
      default: begin
        sim_count = sim_count - 16'd1;
        if (sim_count == '0) sim_phase = PH_WAIT;
      end
    endcase
  endfunction

  function automatic keypad_obs_t predict_keypad_outputs(input keypad_req_t req);
    keypad_obs_t obs;
    logic [1:0]  word_lo;
    word_lo = {req.off[1], 1'b0};
    obs.rdata = '0;
    case (req.act)
      kmki_pkg::ACT_TICK:      advance_tick();
      kmki_pkg::ACT_QUEUE_KEY: begin
        key_fifo[fifo_wr] = req.key;
        fifo_wr = fifo_wr + 4'd1;
      end
      kmki_pkg::ACT_READ_BYTE: obs.rdata = {8'd0, win_bytes[req.off]};
      kmki_pkg::ACT_READ_WORD: obs.rdata = {win_bytes[word_lo + 2'd1], win_bytes[word_lo]};
      kmki_pkg::ACT_WRITE_BYTE: begin
        win_bytes[req.off] = req.data[7:0];
        refresh_columns();
      end
      kmki_pkg::ACT_WRITE_WORD: begin
        win_bytes[word_lo] = req.data[7:0];
        win_bytes[word_lo + 2'd1] = req.data[15:8];
        refresh_columns();
      end
      default: ;
    endcase
    obs.col = {win_bytes[1][0], win_bytes[0]};
    obs.held = (sim_phase == PH_DOWN);
    return obs;
  endfunction

  task automatic send_req(input keypad_req_t req, input logic known, input keypad_obs_t given);
    keypad_obs_t obs;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= req.act;
    item_ch.key_code   <= req.key;
    item_ch.offset     <= req.off;
    item_ch.write_data <= req.data;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    obs = predict_keypad_outputs(req);
    pending_obs.push_back(known ? given : obs);
    transfers_in++;
  endtask

  task automatic await_results();
    item_ch.valid <= 1'b0;
    while (pending_obs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic [kmki_pkg::TICK_W-1:0] press,
                             input logic [kmki_pkg::TICK_W-1:0] rel);
    await_results();
    cfg_we    <= 1'b1;
    cfg_index <= kmki_pkg::REG_PRESS_TICKS;
    cfg_data  <= press;
    @(posedge clk);
    press_len = press;
    cfg_index <= kmki_pkg::REG_RELEASE_TICKS;
    cfg_data  <= rel;
    @(posedge clk);
    release_len = rel;
    cfg_we <= 1'b0;
  endtask

  task automatic send_simple(input logic [kmki_pkg::ACTION_W-1:0] act,
                             input logic [kmki_pkg::KEY_W-1:0] key,
                             input logic [kmki_pkg::OFFSET_W-1:0] off,
                             input logic [kmki_pkg::DATA_W-1:0] data);
    send_req('{act, key, off, data}, 1'b0, '0);
  endtask

  // Ticks until the machine is back in wait with nothing queued.
  task automatic tick_until_idle();
    while (sim_phase != PH_WAIT || fifo_rd != fifo_wr)
      send_simple(kmki_pkg::ACT_TICK, '0, '0, '0);
  endtask

  function automatic keypad_req_t random_req();
    keypad_req_t req;
    int pick;
    int kind;
    pick = $urandom_range(99);
    kind = $urandom_range(9);
    req.off  = kmki_pkg::OFFSET_W'($urandom_range(3));
    req.data = kmki_pkg::DATA_W'($urandom_range(65535));
    if (kind == 0) req.key = kmki_pkg::KEY_NONE;
    else if (kind == 1) req.key = kmki_pkg::KEY_STOP;
    else if (kind == 2) req.key = kmki_pkg::KEY_W'($urandom_range(63, 56));
    else req.key = kmki_pkg::KEY_W'($urandom_range(54, 1));
    if (pick < 48) req.act = kmki_pkg::ACT_TICK;
    else if (pick < 60) req.act = kmki_pkg::ACT_QUEUE_KEY;
    else if (pick < 70) req.act = kmki_pkg::ACT_READ_BYTE;
    else if (pick < 78) req.act = kmki_pkg::ACT_READ_WORD;
    else if (pick < 86) req.act = kmki_pkg::ACT_WRITE_BYTE;
    else if (pick < 96) req.act = kmki_pkg::ACT_WRITE_WORD;
    else if (pick < 98) req.act = ACT_RSVD6;
    else req.act = ACT_RSVD7;
    // Keep the row lines mostly enabled so that presses show up on the columns.
    if (req.act == kmki_pkg::ACT_WRITE_WORD && req.off[1] && $urandom_range(3) != 0)
      req.data = req.data | 16'h000e;
    return req;
  endfunction

  task automatic run_random(input int count, input logic [kmki_pkg::TICK_W-1:0] press,
                            input logic [kmki_pkg::TICK_W-1:0] rel, input int tx_pct,
                            input int rx_pct, input bit squeeze);
    int burst;
    write_config(press, rel);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 3) rx_hold_req = 1'b1;
      if (squeeze && i == 2 * count / 3) await_results();
      // A burst of pushes that laps the ring over unread keys.
      if ($urandom_range(59) == 0) begin
        burst = kmki_pkg::QUEUE_DEPTH + int'($urandom_range(2));
        for (int j = 0; j < burst; j++)
          send_simple(kmki_pkg::ACT_QUEUE_KEY, kmki_pkg::KEY_W'($urandom_range(63)),
                      kmki_pkg::OFFSET_W'($urandom_range(3)),
                      kmki_pkg::DATA_W'($urandom_range(65535)));
      end
      send_req(random_req(), 1'b0, '0);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    keypad_obs_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_obs.size() == 0) begin
        report_mismatch("unexpected result", result_ch.read_data, '0);
      end else begin
        want = pending_obs.pop_front();
        if (result_ch.read_data !== want.rdata)
          report_mismatch("read_data", result_ch.read_data, want.rdata);
        if (result_ch.column_word !== want.col)
          report_mismatch("column_word", kmki_pkg::DATA_W'(result_ch.column_word),
                          kmki_pkg::DATA_W'(want.col));
        if (result_ch.key_held !== want.held)
          report_mismatch("key_held", kmki_pkg::DATA_W'(result_ch.key_held),
                          kmki_pkg::DATA_W'(want.held));
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_obs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    errors = 0;
    transfers_in = 0;
    results_seen = 0;
    presses = 0;
    stops_dropped = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b0;
    sim_phase = PH_WAIT;
    sim_count = '0;
    fifo_rd = '0;
    fifo_wr = '0;
    held_key = kmki_pkg::KEY_NONE;
    press_len = kmki_pkg::TICKS_RESET;
    release_len = kmki_pkg::TICKS_RESET;
    for (int i = 0; i < kmki_pkg::QUEUE_DEPTH; i++) key_fifo[i] = '0;
    for (int i = 0; i < 4; i++) win_bytes[i] = '0;

    cfg_we             <= 1'b0;
    cfg_index          <= kmki_pkg::REG_PRESS_TICKS;
    cfg_data           <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.action     <= kmki_pkg::ACT_TICK;
    item_ch.key_code   <= kmki_pkg::KEY_NONE;
    item_ch.offset     <= '0;
    item_ch.write_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_req(SCRIPT[i].req, SCRIPT[i].known, SCRIPT[i].obs);
    // Let the queued stop, unknown, empty and real keys play out at the reset timing.
    tick_until_idle();

    run_random(RANDOM_ITEMS, 16'd1, 16'd1, 30, 60, 1'b0);
    run_random(RANDOM_ITEMS, 16'd4, 16'd2, 60, 30, 1'b1);

    // Longer presses and gaps, each side in turn the longer one.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    tick_until_idle();
    write_config(16'd40, 16'd25);
    send_simple(kmki_pkg::ACT_WRITE_WORD, '0, 2'd2, 16'h000e);
    send_simple(kmki_pkg::ACT_QUEUE_KEY, 6'd39, '0, '0);
    tick_until_idle();
    write_config(16'd25, 16'd40);
    send_simple(kmki_pkg::ACT_QUEUE_KEY, 6'd18, '0, '0);
    tick_until_idle();

    run_random(RANDOM_ITEMS, 16'd3, 16'd7, 0, 0, 1'b0);

    await_results();
    repeat (5) @(posedge clk);
    if (pending_obs.size() != 0)
      report_mismatch("missing results", kmki_pkg::DATA_W'(pending_obs.size()), '0);
    $display("Ran %0d transfers in and checked %0d results: %0d key presses, %0d stop codes,",
             transfers_in, results_seen, presses, stops_dropped);
    $display("queue wraps, odd word offsets, unused actions and tick counts from 1 to 40.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== keypad_matrix_key_injector.f =====
rtl/core/kmki_pkg.sv
rtl/core/kmki_item_if.sv
rtl/core/kmki_result_if.sv
rtl/core/kmki_queue.sv
rtl/core/keypad_matrix_key_injector.sv
test/tb_keypad_matrix_key_injector.sv
